// ===== hdl/skh_pkg.sv =====
// shared types, constants and helper functions for the short key hash block
// no dependencies; used by the interfaces and every module under hdl
package skh_pkg;

  localparam int KeyLenW       = 31;
  localparam int WordW         = 64;
  localparam int SeedW         = 32;
  localparam int BlockBytes    = 16;
  localparam int RoundCount    = 11;
  localparam int RoundW        = 4;
  localparam int QueueDepthDef = 2;

  localparam logic [WordW-1:0]  InitConst = 64'hDEAD_BEEF_DEAD_BEEF;
  localparam logic [RoundW-1:0] RoundLast = RoundW'(RoundCount - 1);

  // one classified block as it waits for the mixing engine
  typedef struct packed {
    logic               start;
    logic               empty_blk;
    logic               last;
    logic [KeyLenW-1:0] len;
    logic [WordW-1:0]   lo;
    logic [WordW-1:0]   hi;
  } skh_blk_t;

  function automatic logic [5:0] round_rot(input logic [RoundW-1:0] rnd);
    logic [5:0] r;
    unique case (rnd)
      4'd0:    r = 6'd15;
      4'd1:    r = 6'd52;
      4'd2:    r = 6'd26;
      4'd3:    r = 6'd51;
      4'd4:    r = 6'd28;
      4'd5:    r = 6'd9;
      4'd6:    r = 6'd47;
      4'd7:    r = 6'd54;
      4'd8:    r = 6'd32;
      4'd9:    r = 6'd25;
      4'd10:   r = 6'd63;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [WordW-1:0] rotl64(input logic [WordW-1:0] x,
                                              input logic [5:0] r);
    logic [2*WordW-1:0] t;
    t = {x, x} << r;
    return t[2*WordW-1:WordW];
  endfunction

endpackage

// ===== hdl/skh_if.sv =====
// valid/ready channel interfaces for key blocks, hash results and the seed
// depends on skh_pkg
interface skh_in_if import skh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               start_message;
  logic [KeyLenW-1:0] remaining_len;
  logic [WordW-1:0]   data_lo;
  logic [WordW-1:0]   data_hi;

  modport source (output valid, start_message, remaining_len, data_lo, data_hi,
                  input ready);
  modport sink   (input valid, start_message, remaining_len, data_lo, data_hi,
                  output ready);
endinterface

interface skh_out_if import skh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] hash_lo;
  logic [WordW-1:0] hash_hi;

  modport source (output valid, hash_lo, hash_hi, input ready);
  modport sink   (input valid, hash_lo, hash_hi, output ready);
endinterface

interface skh_cfg_if import skh_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SeedW-1:0] seed;

  modport source (output valid, seed, input ready);
  modport sink   (input valid, seed, output ready);
endinterface

// ===== hdl/skh_front.sv =====
// front end: accepts key blocks, masks the short tail, flags start/empty/last
// and holds classified blocks in a short queue; depends on skh_pkg, skh_if
module skh_front import skh_pkg::*; #(
  parameter int QueueDepth = QueueDepthDef
) (
  input  logic       clk,
  input  logic       rst,
  skh_in_if.sink     key_in,
  output skh_blk_t   q_blk,
  output logic       q_valid,
  input  logic       q_pop
);

  localparam int AddrW = $clog2(QueueDepth);
  localparam int CntW  = $clog2(QueueDepth + 1);

  skh_blk_t           mem [QueueDepth];
  logic [AddrW-1:0]   wr_ptr;
  logic [AddrW-1:0]   rd_ptr;
  logic [CntW-1:0]    count;
  logic               push;
  skh_blk_t           blk_in;

  assign key_in.ready = (count != CntW'(QueueDepth));
  assign push         = key_in.valid && key_in.ready;
  assign q_valid      = (count != '0);
  assign q_blk        = mem[rd_ptr];

  // keep byte i only while more than i key bytes remain
  always_comb begin
    logic [BlockBytes*8-1:0] data;
    data = {key_in.data_hi, key_in.data_lo};
    for (int i = 0; i < BlockBytes; i++) begin
      if (key_in.remaining_len <= KeyLenW'(i)) begin
        data[i*8 +: 8] = 8'h00;
      end
    end
    blk_in.start     = key_in.start_message;
    blk_in.empty_blk = (key_in.remaining_len == '0);
    blk_in.last      = (key_in.remaining_len <= KeyLenW'(BlockBytes));
    blk_in.len       = key_in.remaining_len;
    blk_in.lo        = data[WordW-1:0];
    blk_in.hi        = data[2*WordW-1:WordW];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= blk_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AddrW'(QueueDepth - 1)) ? '0 : wr_ptr + AddrW'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == AddrW'(QueueDepth - 1)) ? '0 : rd_ptr + AddrW'(1);
      end
      count <= count + CntW'(push) - CntW'(q_pop);
    end
  end

endmodule

// ===== hdl/skh_back.sv =====
// back end: seed and output registers, four-word mixing engine at one round
// a cycle (a key's last round waits on a held hash); needs skh_pkg, skh_if
module skh_back import skh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  skh_cfg_if.sink    cfg,
  input  skh_blk_t   q_blk,
  input  logic       q_valid,
  output logic       q_pop,
  skh_out_if.source  hash_out
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_MIX  = 1'b1;

  logic                    st;
  logic [RoundW-1:0]       rnd;
  logic                    cur_last;
  logic [WordW-1:0]        a, b, c, d;
  logic signed [SeedW-1:0] seed;
  logic                    res_valid;
  logic [WordW-1:0]        res_lo, res_hi;

  logic             slot_free;
  logic [WordW-1:0] seed_ext, a0, b0, c0, d0, len_ext;
  logic [WordW-1:0] x, y, xr, y_new;
  logic             round_step, mix_done, emit;
  logic [WordW-1:0] emit_lo, emit_hi;

  assign cfg.ready        = 1'b1;
  assign hash_out.valid   = res_valid;
  assign hash_out.hash_lo = res_lo;
  assign hash_out.hash_hi = res_hi;

  assign slot_free = !res_valid || hash_out.ready;
  assign seed_ext  = {{(WordW-SeedW){seed[SeedW-1]}}, seed};
  assign len_ext   = {{(WordW-KeyLenW){1'b0}}, q_blk.len};
  assign a0        = q_blk.start ? seed_ext  : a;
  assign b0        = q_blk.start ? seed_ext  : b;
  assign c0        = q_blk.start ? InitConst : c;
  assign d0        = q_blk.start ? InitConst : d;

  assign q_pop = q_valid && (st == ST_IDLE) && (!q_blk.empty_blk || slot_free);

  // round roles cycle through (d,c) (a,d) (b,a) (c,b)
  always_comb begin
    unique case (rnd[1:0])
      2'd0:    begin x = c; y = d; end
      2'd1:    begin x = d; y = a; end
      2'd2:    begin x = a; y = b; end
      default: begin x = b; y = c; end
    endcase
    xr    = rotl64(x, round_rot(rnd));
    y_new = (y ^ x) + xr;
  end

  assign mix_done   = (st == ST_MIX) && (rnd == RoundLast);
  assign round_step = (st == ST_MIX) && (!mix_done || !cur_last || slot_free);
  assign emit       = (q_pop && q_blk.empty_blk) || (mix_done && cur_last && slot_free);
  assign emit_lo    = (st == ST_MIX) ? xr    : a0;
  assign emit_hi    = (st == ST_MIX) ? y_new : b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg.valid) begin
      seed <= cfg.seed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      rnd      <= '0;
      cur_last <= 1'b0;
      a        <= '0;
      b        <= '0;
      c        <= '0;
      d        <= '0;
    end else if (q_pop) begin
      cur_last <= q_blk.last;
      rnd      <= '0;
      if (q_blk.empty_blk) begin
        a <= a0;
        b <= b0;
        c <= c0;
        d <= d0;
      end else begin
        a  <= a0 ^ len_ext;
        b  <= b0 ^ ~len_ext;
        c  <= c0 + q_blk.lo;
        d  <= d0 + q_blk.hi;
        st <= ST_MIX;
      end
    end else if (round_step) begin
      unique case (rnd[1:0])
        2'd0:    begin c <= xr; d <= y_new; end
        2'd1:    begin d <= xr; a <= y_new; end
        2'd2:    begin a <= xr; b <= y_new; end
        default: begin b <= xr; c <= y_new; end
      endcase
      if (mix_done) begin
        st <= ST_IDLE;
      end else begin
        rnd <= rnd + RoundW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (hash_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_lo <= emit_lo;
      res_hi <= emit_hi;
    end
  end

  a_rnd_range: assert property (@(posedge clk) disable iff (rst)
    st == ST_MIX |-> rnd <= RoundLast)
    else $error("round counter past last round");

  a_mix_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop && !q_blk.empty_blk |=> st == ST_MIX && rnd == '0)
    else $error("nonempty block did not start mixing at round zero");

  a_mix_hold: assert property (@(posedge clk) disable iff (rst)
    st == ST_MIX && rnd != RoundLast |=> st == ST_MIX)
    else $error("mixing left before last round");

  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && !hash_out.ready |=> res_valid)
    else $error("held result dropped");

endmodule

// ===== hdl/short_key_hash128.sv =====
// short_key_hash128 takes a key as 16-byte blocks, one transfer per block, and
// returns the 128-bit hash as one transfer after the last block (remaining
// length at most 16). The mixing engine folds in a nonempty block's length and
// words, then eleven add-xor-rotate rounds, one 64-bit round per cycle (a
// key's last round waits on a held hash); an empty block's hash goes straight
// out. Up to QueueDepth classified blocks queue ahead of the engine, so the
// key input keeps taking transfers while a block mixes, and the finished hash
// sits in an output register while the next block is worked on. The seed is to
// be written through the cfg channel between keys; not enforced by the block.
module short_key_hash128 import skh_pkg::*; #(
  parameter int QueueDepth = QueueDepthDef
) (
  input  logic       clk,
  input  logic       rst,
  skh_cfg_if.sink    cfg,
  skh_in_if.sink     key_in,
  skh_out_if.source  hash_out
);

  skh_blk_t q_blk;
  logic     q_valid;
  logic     q_pop;

  skh_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .key_in  (key_in),
    .q_blk   (q_blk),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  skh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_blk    (q_blk),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .hash_out (hash_out)
  );

endmodule

// ===== bench/short_key_hash128_test.sv =====
`timescale 1ns / 100ps
// self-checking bench for short_key_hash128: key blocks, seed writes and hash checks
// depends on skh_pkg and the channel interfaces in skh_if.sv
module short_key_hash128_test;
  import skh_pkg::*;

  localparam int HalfPeriod  = 10;
  localparam int ResetCycles = 4;
  localparam int DrainCycles = 100;
  localparam int HoldCycles  = 400;
  localparam int CycleLimit  = 500000;
  localparam int PhaseCount  = 6;
  localparam int PhaseBlocks = 330;
  localparam int IdlePct     = 11;

  localparam int WA = 0;
  localparam int WB = 1;
  localparam int WC = 2;
  localparam int WD = 3;

  class hash_scoreboard;
    logic [WordW-1:0]   st [4];
    logic [SeedW-1:0]   seed;
    logic [2*WordW-1:0] expected_q [$];
    int                 errors;
    int                 checked;

    function new();
      seed = '0;
      foreach (st[i]) st[i] = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_seed(logic [SeedW-1:0] s);
      seed = s;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [WordW-1:0] rotl(logic [WordW-1:0] x, int r);
      return (x << r) | (x >> (WordW - r));
    endfunction

    function void mix_round(int y, int x, int r);
      logic [WordW-1:0] xr;
      xr = rotl(st[x], r);
      st[y] = (st[y] ^ st[x]) + xr;
      st[x] = xr;
    endfunction

    function void note_block(logic start, logic [KeyLenW-1:0] len,
                             logic [WordW-1:0] lo, logic [WordW-1:0] hi);
      logic [WordW-1:0] w_lo;
      logic [WordW-1:0] w_hi;
      int               n;
      w_lo = lo;
      w_hi = hi;
      n = int'(len);
      if (start) begin
        st[WA] = {{(WordW-SeedW){seed[SeedW-1]}}, seed};
        st[WB] = {{(WordW-SeedW){seed[SeedW-1]}}, seed};
        st[WC] = InitConst;
        st[WD] = InitConst;
      end
      if (len != 0) begin
        st[WA] = st[WA] ^ {{(WordW-KeyLenW){1'b0}}, len};
        st[WB] = st[WB] ^ ~{{(WordW-KeyLenW){1'b0}}, len};
        // short tail: bytes past the key end count as zero
        if (len < 8) begin
          w_lo = lo & ((64'd1 << (8 * n)) - 64'd1);
          w_hi = '0;
        end else if (len < 16) begin
          w_hi = (len == 8) ? '0 : (hi & ((64'd1 << (8 * (n - 8))) - 64'd1));
        end
        st[WC] = st[WC] + w_lo;
        st[WD] = st[WD] + w_hi;
        mix_round(WD, WC, 15);
        mix_round(WA, WD, 52);
        mix_round(WB, WA, 26);
        mix_round(WC, WB, 51);
        mix_round(WD, WC, 28);
        mix_round(WA, WD, 9);
        mix_round(WB, WA, 47);
        mix_round(WC, WB, 54);
        mix_round(WD, WC, 32);
        mix_round(WA, WD, 25);
        mix_round(WB, WA, 63);
      end
      if (len <= 16) expected_q.push_back({st[WB], st[WA]});
    endfunction

    function void check_hash(logic [WordW-1:0] lo, logic [WordW-1:0] hi);
      logic [2*WordW-1:0] want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected hash transfer: expected none actual lo %h hi %h",
                 $time, lo, hi);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (lo !== want[WordW-1:0]) begin
        errors++;
        $display("%0t: hash_lo mismatch: expected %h actual %h",
                 $time, want[WordW-1:0], lo);
      end
      if (hi !== want[2*WordW-1:WordW]) begin
        errors++;
        $display("%0t: hash_hi mismatch: expected %h actual %h",
                 $time, want[2*WordW-1:WordW], hi);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  skh_cfg_if cfg_ch ();
  skh_in_if  key_ch ();
  skh_out_if hash_ch ();

  short_key_hash128 uut (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_ch),
    .key_in   (key_ch),
    .hash_out (hash_ch)
  );

  hash_scoreboard sb = new();

  logic calm = 1'b0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   cycle_count = 0;
  int   blocks_sent = 0;
  int   seeds_written = 0;

  always #HalfPeriod clk = ~clk;

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      hash_ch.ready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        hash_ch.ready <= 1'b0;
      end else begin
        hash_ch.ready <= calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (key_ch.valid && key_ch.ready)
        sb.note_block(key_ch.start_message, key_ch.remaining_len,
                      key_ch.data_lo, key_ch.data_hi);
      if (hash_ch.valid && hash_ch.ready)
        sb.check_hash(hash_ch.hash_lo, hash_ch.hash_hi);
    end
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [WordW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned rand_key_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 40) return $urandom_range(16, 1);
    if (r < 75) return $urandom_range(48, 17);
    if (r < 95) return $urandom_range(128, 49);
    return $urandom_range(400, 129);
  endfunction

  task automatic send_block(input logic start, input logic [KeyLenW-1:0] len,
                            input logic [WordW-1:0] lo, input logic [WordW-1:0] hi);
    if (!calm) begin
      while ($urandom_range(99) < IdlePct) begin
        key_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    key_ch.valid         <= 1'b1;
    key_ch.start_message <= start;
    key_ch.remaining_len <= len;
    key_ch.data_lo       <= lo;
    key_ch.data_hi       <= hi;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
    blocks_sent++;
  endtask

  task automatic send_key(input int unsigned total_len, input logic with_start);
    int unsigned rem;
    logic        first;
    logic        done;
    rem = total_len;
    first = with_start;
    done = 1'b0;
    while (!done) begin
      send_block(first, KeyLenW'(rem), rand_word(), rand_word());
      first = 1'b0;
      if (rem <= 16) done = 1'b1;
      else rem -= 16;
    end
  endtask

  task automatic send_random_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) send_key(rand_key_len(), 1'b1);
    else if (r < 88) send_key($urandom_range(40, 0), 1'b0);
    else if (r < 94) send_block(1'($urandom_range(1)), KeyLenW'($urandom),
                                rand_word(), rand_word());
    else send_block(1'($urandom_range(1)), KeyLenW'($urandom_range(16, 0)),
                    $urandom_range(1) ? '1 : '0, $urandom_range(1) ? '1 : '0);
  endtask

  // only between keys, once every hash has come back and the engine has gone quiet
  task automatic write_seed(input logic signed [SeedW-1:0] value);
    key_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.seed  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.set_seed(value);
    seeds_written++;
  endtask

  task automatic run_directed();
    // no start straight out of reset
    send_block(1'b0, 31'd5, rand_word(), rand_word());
    send_block(1'b1, 31'd0, '1, '1);
    send_block(1'b1, 31'd16, '1, '1);
    send_block(1'b1, 31'd16, '0, '0);
    send_block(1'b1, 31'd1, '1, '1);
    send_block(1'b1, 31'd7, '1, '1);
    send_block(1'b1, 31'd8, '1, '1);
    send_block(1'b1, 31'd9, '1, '1);
    send_block(1'b1, 31'd15, '1, '1);
    send_block(1'b1, 31'd17, '1, '1);
    send_block(1'b0, 31'd1, '1, '1);
    send_block(1'b1, 31'd32, rand_word(), rand_word());
    send_block(1'b0, 31'd16, rand_word(), rand_word());
    send_block(1'b1, {KeyLenW{1'b1}}, '1, '1);
    send_block(1'b0, 31'd16, rand_word(), rand_word());
    send_block(1'b0, 31'd0, '0, '0);
    send_block(1'b1, 31'd0, rand_word(), rand_word());
    send_block(1'b0, 31'd0, rand_word(), rand_word());
  endtask

  initial begin
    logic signed [SeedW-1:0] next_seed;
    key_ch.valid         <= 1'b0;
    key_ch.start_message <= 1'b0;
    key_ch.remaining_len <= '0;
    key_ch.data_lo       <= '0;
    key_ch.data_hi       <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.seed          <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: next_seed = 32'sh8000_0000;
        1: next_seed = 32'sh7fff_ffff;
        2: next_seed = -32'sd1;
        3: next_seed = 32'sd0;
        default: next_seed = $urandom;
      endcase
      write_seed(next_seed);
      send_block(1'b1, 31'd0, rand_word(), rand_word());
      if (p == 3) begin
        // stalled result side: the sender keeps offering until the input backs up
        calm = 1'b1;
        hold_req++;
        for (int k = 0; k < 40; k++) send_key($urandom_range(16, 0), 1'b1);
        calm = 1'b0;
      end
      calm = (p == 2);
      while (blocks_sent < 25 + (p + 1) * PhaseBlocks) send_random_item();
      calm = 1'b0;
    end

    key_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d key blocks under %0d seed settings, checked %0d hashes",
             blocks_sent, seeds_written + 1, sb.checked);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
